@@ rtl/rhc_pkg.sv @@
// rhc_pkg: shared types, register indexes and hash constants for the
// rolling hash chunker. No dependencies.
`default_nettype none

package rhc_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUT_TARGET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK  = CFG_IDX_W'(1);

    // reset values of the registers
    localparam logic [7:0]  CUT_TARGET_RST = 8'd0;
    localparam logic [15:0] MAX_CHUNK_RST  = 16'd8191;

    // one input item: a byte of the buffer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // one result item: a chunk boundary
    typedef struct packed {
        logic [31:0] boundary_pos;
        logic        forced_cut;
        logic        is_final;
    } cut_item_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [7:0]  cut_target;
        logic [15:0] max_chunk;
    } chunk_cfg_t;

    // 3^n modulo 2^8. Only the hash low byte is ever compared, and the
    // low byte of a sum of products modulo 2^64 depends only on the low
    // bytes of its terms, so the hash is carried in 8 bits.
    function automatic logic [7:0] pow3_mod256(input int n);
        logic [7:0] w;
        w = 8'd1;
        for (int k = 0; k < n; k++)
        begin
            w = 8'(w * 8'd3);
        end
        return w;
    endfunction

endpackage : rhc_pkg

`default_nettype wire

@@ rtl/rolling_hash_chunker.sv @@
// An accepted byte is held in the input register; when it advances, any
// boundary it produces is captured in the result register.
// Throughput: one byte per cycle sustained; the input register and the
// result register are both elastic, so a stalled result does not stop
// intake until both stages hold an item.
// Reset (rst_n, async, active low): empty pipeline, zero window, hash and
// offsets; cut_target 0, max_chunk 8191. No clearing pass is needed.
// rolling_hash_chunker: top level with input register and result register.
// Depends on rhc_pkg, rhc_cfg, rhc_core.
`default_nettype none

module rolling_hash_chunker
    import rhc_pkg::*;
#(
    parameter int WINDOW_BYTES = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // byte channel
    input  wire logic                  byte_valid,
    output logic                       byte_ready,
    input  wire byte_item_t            byte_item,
    // cut channel
    output logic                       cut_valid,
    input  wire logic                  cut_ready,
    output cut_item_t                  cut_item,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    chunk_cfg_t cfg;
    byte_item_t s1_item_reg;
    logic       s1_valid_reg, s1_valid_next;
    cut_item_t  out_item_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_free, step, res_fire;
    cut_item_t  res;

    rhc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rhc_core #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (s1_item_reg),
        .cfg      (cfg),
        .res_fire (res_fire),
        .res      (res)
    );

    // pipeline control
    always_comb
    begin
        out_free       = !out_valid_reg || cut_ready;
        step           = s1_valid_reg && out_free;
        byte_ready     = !s1_valid_reg || step;
        s1_valid_next  = byte_ready ? byte_valid : s1_valid_reg;
        out_valid_next = out_free ? (step && res_fire) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            s1_item_reg <= byte_item;
        end
        if (step && res_fire && out_free)
        begin
            out_item_reg <= res;
        end
    end

    assign cut_valid = out_valid_reg;
    assign cut_item  = out_item_reg;

    // an empty input stage always takes a byte
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> byte_ready)
        else $error("input stage empty but not ready");

    // a final result never claims a forced cut
    a_final_not_forced: assert property (@(posedge clk) disable iff (!rst_n)
        cut_valid |-> !(cut_item.is_final && cut_item.forced_cut))
        else $error("final boundary marked as forced cut");

    // a held byte advances whenever the result side can take it
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_free |-> step)
        else $error("pipeline stalled with a free result register");

endmodule : rolling_hash_chunker

`default_nettype wire

@@ rtl/rhc_cfg.sv @@
// rhc_cfg: configuration register file (cut target and maximum chunk length).
// Depends on rhc_pkg.
`default_nettype none

module rhc_cfg
    import rhc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output chunk_cfg_t                 cfg
);

    chunk_cfg_t cfg_reg;
    chunk_cfg_t cfg_next;

    // decode writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CUT_TARGET: cfg_next.cut_target = cfg_wdata[7:0];
                REG_MAX_CHUNK:  cfg_next.max_chunk  = cfg_wdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_target <= CUT_TARGET_RST;
            cfg_reg.max_chunk  <= MAX_CHUNK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : rhc_cfg

`default_nettype wire

@@ rtl/rhc_core.sv @@
// rhc_core: window shift line, 8-bit rolling hash, offsets and cut decision.
// One byte is consumed per step. Depends on rhc_pkg.
`default_nettype none

module rhc_core
    import rhc_pkg::*;
#(
    parameter int WINDOW_BYTES = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire byte_item_t item,
    input  wire chunk_cfg_t cfg,
    output logic            res_fire,
    output cut_item_t       res
);

    // weight dropped with the oldest byte, and first judged offset
    localparam logic [7:0]  OUT_WEIGHT = pow3_mod256(WINDOW_BYTES + 1);
    localparam logic [31:0] JUDGE_POS  = 32'(2 * WINDOW_BYTES - 1);
    localparam logic [31:0] START_OFS  = 32'(WINDOW_BYTES - 1);

    logic [7:0]  win_reg [WINDOW_BYTES];
    logic [7:0]  win_next [WINDOW_BYTES];
    logic [7:0]  hash_reg, hash_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] last_cut_reg, last_cut_next;

    logic [7:0]  hash_roll;
    logic [31:0] start;
    logic        judged, hit, full;

    // rolling update: h*3 - oldest*3^(W+1) + b*3, low byte only
    always_comb
    begin
        hash_roll = 8'(8'(hash_reg * 8'd3) - 8'(win_reg[0] * OUT_WEIGHT)
                       + 8'(item.data_byte * 8'd3));
        start     = count_reg - START_OFS;
        judged    = count_reg >= JUDGE_POS;
        hit       = hash_roll == cfg.cut_target;
        full      = (start - last_cut_reg) >= {16'd0, cfg.max_chunk};
    end

    // next state and result
    always_comb
    begin
        for (int k = 0; k < WINDOW_BYTES - 1; k++)
        begin
            win_next[k] = win_reg[k+1];
        end
        win_next[WINDOW_BYTES-1] = item.data_byte;
        hash_next     = hash_roll;
        count_next    = count_reg + 32'd1;
        last_cut_next = last_cut_reg;
        res_fire      = 1'b0;
        res.boundary_pos = count_reg + 32'd1;
        res.forced_cut   = 1'b0;
        res.is_final     = 1'b0;

        if (item.last_byte)
        begin
            // closing boundary, then start a fresh buffer
            res_fire      = 1'b1;
            res.is_final  = 1'b1;
            for (int k = 0; k < WINDOW_BYTES; k++)
            begin
                win_next[k] = 8'd0;
            end
            hash_next     = 8'd0;
            count_next    = 32'd0;
            last_cut_next = 32'd0;
        end
        else if (judged && (hit || full))
        begin
            res_fire         = 1'b1;
            res.boundary_pos = start;
            res.forced_cut   = !hit;
            last_cut_next    = start;
        end
    end

    // window shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_BYTES; k++)
            begin
                win_reg[k] <= 8'd0;
            end
        end
        else if (step)
        begin
            for (int k = 0; k < WINDOW_BYTES; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // hash and offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg     <= 8'd0;
            count_reg    <= 32'd0;
            last_cut_reg <= 32'd0;
        end
        else if (step)
        begin
            hash_reg     <= hash_next;
            count_reg    <= count_next;
            last_cut_reg <= last_cut_next;
        end
    end

    // final byte returns the stream state to its reset values
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=>
            count_reg == 32'd0 && last_cut_reg == 32'd0 && hash_reg == 8'd0)
        else $error("stream state not cleared after final byte");

    // an ordinary byte advances the offset by one
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.last_byte |=> count_reg == $past(count_reg) + 32'd1)
        else $error("byte offset did not advance");

    // a non-final cut only comes from a judged window
    a_cut_judged: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && !res.is_final |-> judged && !item.last_byte)
        else $error("cut reported outside a judged window");

    // a cut moves the last cut to its window start
    a_last_cut_moves: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_fire && !res.is_final |=> last_cut_reg == $past(start))
        else $error("last cut not updated on a cut");

endmodule : rhc_core

`default_nettype wire
